// ----- src/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants for the HSV to RGB converter
// Fixed-point formats, angle constants and the hue folding helpers.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int LEVEL_FRAC_BITS = 12;
   localparam int HUE_FRAC_BITS   = 4;

   localparam int HUE_W   = 16;
   localparam int LEVEL_W = 13;

   localparam int LEVEL_ONE = 1 << LEVEL_FRAC_BITS;
   localparam int DEG60     = 60 << HUE_FRAC_BITS;
   localparam int DEG360    = 360 << HUE_FRAC_BITS;

   // folded hue (below 360 degrees) and position within one sector
   localparam int FOLD_W = $clog2(DEG360);
   localparam int TRI_W  = $clog2(DEG60 + 1);

   // largest hue magnitude over 360 degrees, in whole turns
   localparam int MAX_TURNS = (1 << (HUE_W - 1)) / DEG360;

   // 60 degrees is 15 << (HUE_FRAC_BITS + 2): shift out the power of two,
   // then divide by 15 with a reciprocal that is exact below 2^16
   localparam int DIV_SHIFT   = HUE_FRAC_BITS + 2;
   localparam int RECIP15     = 34953;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 16;

   localparam int PROD_W = LEVEL_W + TRI_W;
   localparam int QUOT_W = PROD_W - DIV_SHIFT;

   typedef enum logic [2:0] {
      SECT_R_Y = 3'd0,
      SECT_Y_G = 3'd1,
      SECT_G_C = 3'd2,
      SECT_C_B = 3'd3,
      SECT_B_M = 3'd4,
      SECT_M_R = 3'd5
   } sector_type;

   // remainder of the hue magnitude modulo 360 degrees
   function automatic logic [FOLD_W-1:0] hue_fold(input logic [HUE_W-1:0] mag);
      logic [HUE_W-1:0] rem;
      rem = mag;
      for (int k = 1; k <= MAX_TURNS; k++) begin
         if (mag >= HUE_W'(k * DEG360)) begin
            rem = mag - HUE_W'(k * DEG360);
         end
      end
      return rem[FOLD_W-1:0];
   endfunction

   // 60-degree sector of a folded hue
   function automatic logic [2:0] hue_sector(input logic [FOLD_W-1:0] h);
      logic [2:0] sect;
      sect = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (h >= FOLD_W'(k * DEG60)) begin
            sect = 3'(k);
         end
      end
      return sect;
   endfunction

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
      return (lvl > LEVEL_W'(LEVEL_ONE)) ? LEVEL_W'(LEVEL_ONE) : lvl;
   endfunction

endpackage

// ----- src/hsv_to_rgb_convert.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert: pipelined HSV to RGB colour conversion
// Six register stages: magnitude, fold and chroma, sector, product, divide, mix.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_hue (signed, 1/16 degree), req_saturation and req_brightness
//   (4096 = 1.0, larger values clamp to 1.0) and raise start. A transaction
//   is taken at every rising edge with start high and busy low.
//   busy follows reset and is low otherwise, so one transaction can enter
//   every cycle: throughput is one pixel per clock.
//   rsp_valid rises when the transaction leaves the mix stage, with rsp_red,
//   rsp_green and rsp_blue on the same cycle. The strobe lasts one cycle,
//   and results leave in the order taken.
//   The pipeline is free-running; the receiver cannot stall it and takes
//   each result in the cycle it appears.
//   Reset (synchronous) drops every transaction in flight; nothing else
//   is held between transactions.
//   The depth is set by the two multipliers: value times saturation, and
//   chroma times the triangle ramp, each followed by its own register,
//   plus a reciprocal multiply for the divide by 60 degrees.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert
   import hsv2rgb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [HUE_W-1:0]   req_hue,
   input  logic [LEVEL_W-1:0]        req_saturation,
   input  logic [LEVEL_W-1:0]        req_brightness,
   output logic                      rsp_valid,
   output logic [LEVEL_W-1:0]        rsp_red,
   output logic [LEVEL_W-1:0]        rsp_green,
   output logic [LEVEL_W-1:0]        rsp_blue
);

   localparam int DEPTH = 6;

   logic                   accept;
   logic [DEPTH-1:0]       vld_ff, vld_in;

   // stage 1: magnitude and clamp
   logic [HUE_W-1:0]       mag_ff, mag_in;
   logic [LEVEL_W-1:0]     sat1_ff, sat1_in;
   logic [LEVEL_W-1:0]     bri1_ff, bri1_in;

   // stage 2: fold and chroma
   logic [2*LEVEL_W-1:0]   vs_prod;
   logic [FOLD_W-1:0]      fold_ff, fold_in;
   logic [LEVEL_W-1:0]     chroma2_ff, chroma2_in;
   logic [LEVEL_W-1:0]     bri2_ff;

   // stage 3: sector, ramp, offset
   sector_type             sect3_ff, sect3_in;
   logic [FOLD_W-1:0]      resid;
   logic [TRI_W-1:0]       tri_ff, tri_in;
   logic [LEVEL_W-1:0]     chroma3_ff;
   logic [LEVEL_W-1:0]     base3_ff, base3_in;

   // stage 4: chroma times ramp
   logic [PROD_W-1:0]      ctri_ff, ctri_in;
   sector_type             sect4_ff;
   logic [LEVEL_W-1:0]     chroma4_ff;
   logic [LEVEL_W-1:0]     base4_ff;

   // stage 5: divide by 60 degrees
   logic [QUOT_W-1:0]      quot;
   logic [QUOT_W+RECIP_W-1:0] recip_prod;
   logic [LEVEL_W-1:0]     xval_ff, xval_in;
   sector_type             sect5_ff;
   logic [LEVEL_W-1:0]     chroma5_ff;
   logic [LEVEL_W-1:0]     base5_ff;

   // stage 6: channel order and offset
   logic [LEVEL_W-1:0]     red_ff, red_in;
   logic [LEVEL_W-1:0]     green_ff, green_in;
   logic [LEVEL_W-1:0]     blue_ff, blue_in;

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[DEPTH-2:0], accept};

   always_comb begin
      mag_in  = req_hue[HUE_W-1] ? HUE_W'(-req_hue) : HUE_W'(req_hue);
      sat1_in = sat_level(req_saturation);
      bri1_in = sat_level(req_brightness);
   end

   always_comb begin
      fold_in    = hue_fold(mag_ff);
      vs_prod    = sat1_ff * bri1_ff;
      chroma2_in = vs_prod[LEVEL_FRAC_BITS +: LEVEL_W];
   end

   // even sector: ramp rises with the residue; odd sector: it falls
   always_comb begin
      sect3_in = sector_type'(hue_sector(fold_ff));
      resid    = fold_ff - FOLD_W'(int'(sect3_in) * DEG60);
      if (sect3_in[0]) begin
         tri_in = TRI_W'(DEG60) - resid[TRI_W-1:0];
      end else begin
         tri_in = resid[TRI_W-1:0];
      end
      base3_in = bri2_ff - chroma2_ff;
   end

   assign ctri_in = chroma3_ff * tri_ff;

   always_comb begin
      quot       = ctri_ff[PROD_W-1:DIV_SHIFT];
      recip_prod = quot * RECIP_W'(RECIP15);
      xval_in    = recip_prod[RECIP_SHIFT +: LEVEL_W];
   end

   always_comb begin
      red_in   = base5_ff;
      green_in = base5_ff;
      blue_in  = base5_ff;
      case (sect5_ff)
         SECT_R_Y: begin
            red_in   = base5_ff + chroma5_ff;
            green_in = base5_ff + xval_ff;
         end
         SECT_Y_G: begin
            red_in   = base5_ff + xval_ff;
            green_in = base5_ff + chroma5_ff;
         end
         SECT_G_C: begin
            green_in = base5_ff + chroma5_ff;
            blue_in  = base5_ff + xval_ff;
         end
         SECT_C_B: begin
            green_in = base5_ff + xval_ff;
            blue_in  = base5_ff + chroma5_ff;
         end
         SECT_B_M: begin
            red_in   = base5_ff + xval_ff;
            blue_in  = base5_ff + chroma5_ff;
         end
         default: begin
            red_in   = base5_ff + chroma5_ff;
            blue_in  = base5_ff + xval_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      sat1_ff    <= sat1_in;
      bri1_ff    <= bri1_in;

      fold_ff    <= fold_in;
      chroma2_ff <= chroma2_in;
      bri2_ff    <= bri1_ff;

      sect3_ff   <= sect3_in;
      tri_ff     <= tri_in;
      chroma3_ff <= chroma2_ff;
      base3_ff   <= base3_in;

      ctri_ff    <= ctri_in;
      sect4_ff   <= sect3_ff;
      chroma4_ff <= chroma3_ff;
      base4_ff   <= base3_ff;

      xval_ff    <= xval_in;
      sect5_ff   <= sect4_ff;
      chroma5_ff <= chroma4_ff;
      base5_ff   <= base4_ff;

      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// ----- src/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker: port-level checks for the HSV to RGB converter
// Latency, spurious results, output range and greys as seen on the top level's ports.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [LEVEL_W-1:0]       req_saturation,
   input logic                     rsp_valid,
   input logic [LEVEL_W-1:0]       rsp_red,
   input logic [LEVEL_W-1:0]       rsp_green,
   input logic [LEVEL_W-1:0]       rsp_blue
);

   logic accept;
   assign accept = start && !busy;

   // every transaction taken is followed by a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("result missing six cycles after a transaction");

   // no result without a matching earlier transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without a matching transaction");

   // channels never exceed full scale
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= LEVEL_W'(LEVEL_ONE)) &&
                    (rsp_green <= LEVEL_W'(LEVEL_ONE)) &&
                    (rsp_blue <= LEVEL_W'(LEVEL_ONE)))
      else $error("channel level above full scale");

   // zero saturation gives a grey
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (accept && req_saturation == '0) |->
         ##6 (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not give equal channels");

endmodule

bind hsv_to_rgb_convert hsv2rgb_checker u_hsv2rgb_checker (.*);
